/* design/tasp_pkg.sv */
// ----------------------------------------------------------------------------
// tasp_pkg
// Types, widths and reset values shared by the two-axis servo motion profiler.
// ----------------------------------------------------------------------------
package tasp_pkg;

  localparam int unsigned POS_W  = 11;  // position, goal and command width
  localparam int unsigned NOW_W  = 13;  // internal position, room for overshoot
  localparam int unsigned DLT_W  = 14;  // goal minus position
  localparam int unsigned SPD_W  = 7;   // signed velocity
  localparam int unsigned RAD_W  = 18;  // 2 * accel * |delta|
  localparam int unsigned ROOT_W = 9;   // floor square root of RAD_W bits

  typedef enum logic [2:0] {
    CFG_MAX_VEL    = 3'd0,
    CFG_ACCEL      = 3'd1,
    CFG_CTR_VEL    = 3'd2,
    CFG_CTR_ACCEL  = 3'd3,
    CFG_DEADBAND   = 3'd4,
    CFG_OUT_LIMIT  = 3'd5,
    CFG_RELAX      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0] max_vel;
    logic [3:0] accel;
    logic [5:0] ctr_vel;
    logic [3:0] ctr_accel;
    logic [5:0] deadband;
    logic [9:0] out_limit;
    logic [3:0] relax;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_vel:   6'd12,
    accel:     4'd2,
    ctr_vel:   6'd7,
    ctr_accel: 4'd1,
    deadband:  6'd2,
    out_limit: 10'd150,
    relax:     4'd3
  };

  typedef struct packed {
    logic signed [NOW_W-1:0] now;
    logic signed [POS_W-1:0] goal;
    logic signed [SPD_W-1:0] speed;
    logic [3:0]              cnt;
    logic                    relaxed;
  } axis_state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] goal;
    logic signed [SPD_W-1:0] speed;
    logic [RAD_W-1:0]        radicand;
  } goal_res_t;

  // Clamp a 12-bit signed command to +/- lim.
  function automatic logic signed [POS_W-1:0] clamp_cmd(logic signed [11:0] v,
                                                         logic [9:0] lim);
    logic signed [11:0] hi;
    logic signed [11:0] lo;
    logic signed [11:0] r;
    hi = $signed({2'b00, lim});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[POS_W-1:0];
  endfunction

endpackage

/* design/tasp_ifs.sv */
// ----------------------------------------------------------------------------
// tasp channel interfaces
// Command, position and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tasp_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] x_command;
  logic signed [10:0] y_command;
  modport source (output valid, x_command, y_command, input ready);
  modport sink   (input valid, x_command, y_command, output ready);
endinterface

interface tasp_pos_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] x_position;
  logic signed [10:0] y_position;
  logic               x_written;
  logic               y_written;
  logic               x_pulse_off;
  logic               y_pulse_off;
  modport source (output valid, x_position, y_position, x_written, y_written,
                  x_pulse_off, y_pulse_off, input ready);
  modport sink   (input valid, x_position, y_position, x_written, y_written,
                  x_pulse_off, y_pulse_off, output ready);
endinterface

interface tasp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/two_axis_servo_motion_profiler.sv */
// ----------------------------------------------------------------------------
// two_axis_servo_motion_profiler
// Joystick-driven two-axis servo profiler with square-root braking.
//
//   channel  dir  handshake      payload
//   cfg_i    in   valid/ready    index[2:0], data[9:0]
//   cmd_i    in   valid/ready    x_command, y_command (11b signed)
//   pos_o    out  valid/ready    x/y_position, x/y_written, x/y_pulse_off
//
// Each item runs, per axis, through one goal state, the iteration in the
// shared square-root unit and one move state; then one load.
// The next item is taken once the sequencer is back in idle; a result still
// waiting on pos_o only holds the final load. Config is always ready.
// Reset loads default config and clears all axis state.
// ----------------------------------------------------------------------------
module two_axis_servo_motion_profiler (
  input  logic       clk_i,
  input  logic       rst_ni,
  tasp_cfg_if.sink   cfg_i,
  tasp_cmd_if.sink   cmd_i,
  tasp_pos_if.source pos_o
);
  import tasp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GOAL,
    S_ROOT,
    S_MOVE,
    S_DONE
  } state_e;

  state_e                  state_q;
  cfg_t                    cfg_q;
  axis_state_t             axis_q [2];
  logic signed [POS_W-1:0] req_q [2];
  logic                    sel_q;
  logic [1:0]              wrote_q;
  logic                    pos_valid_q;

  logic signed [POS_W-1:0] x_pos_q;
  logic signed [POS_W-1:0] y_pos_q;
  logic                    x_wr_q;
  logic                    y_wr_q;
  logic                    x_off_q;
  logic                    y_off_q;

  goal_res_t               goal_res;
  axis_state_t             move_res;
  logic                    move_wrote;
  logic                    root_busy;
  logic [ROOT_W-1:0]       root;
  logic                    cmd_acc;
  logic                    load;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign load        = (state_q == S_DONE) && (!pos_valid_q || pos_o.ready);

  tasp_axis_alu u_alu (
    .st_i    (axis_q[sel_q]),
    .req_i   (req_q[sel_q]),
    .cfg_i   (cfg_q),
    .root_i  (root),
    .goal_o  (goal_res),
    .move_o  (move_res),
    .wrote_o (move_wrote)
  );

  tasp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_GOAL),
    .rad_i   (goal_res.radicand),
    .busy_o  (root_busy),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_MAX_VEL:   cfg_q.max_vel   <= cfg_i.data[5:0];
        CFG_ACCEL:     cfg_q.accel     <= cfg_i.data[3:0];
        CFG_CTR_VEL:   cfg_q.ctr_vel   <= cfg_i.data[5:0];
        CFG_CTR_ACCEL: cfg_q.ctr_accel <= cfg_i.data[3:0];
        CFG_DEADBAND:  cfg_q.deadband  <= cfg_i.data[5:0];
        CFG_OUT_LIMIT: cfg_q.out_limit <= cfg_i.data;
        CFG_RELAX:     cfg_q.relax     <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      req_q[0] <= clamp_cmd({cmd_i.x_command[10], cmd_i.x_command}, cfg_q.out_limit);
      req_q[1] <= clamp_cmd(-{cmd_i.y_command[10], cmd_i.y_command}, cfg_q.out_limit);
    end
    if (load) begin
      x_pos_q <= axis_q[0].now[POS_W-1:0];
      y_pos_q <= axis_q[1].now[POS_W-1:0];
      x_wr_q  <= wrote_q[0];
      y_wr_q  <= wrote_q[1];
      x_off_q <= axis_q[0].relaxed;
      y_off_q <= axis_q[1].relaxed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      axis_q[0]   <= '0;
      axis_q[1]   <= '0;
      wrote_q     <= '0;
      pos_valid_q <= 1'b0;
    end else begin
      if (pos_valid_q && pos_o.ready && !load) begin
        pos_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_acc) begin
            sel_q   <= 1'b0;
            state_q <= S_GOAL;
          end
        end
        S_GOAL: begin
          axis_q[sel_q].goal  <= goal_res.goal;
          axis_q[sel_q].speed <= goal_res.speed;
          state_q             <= S_ROOT;
        end
        S_ROOT: begin
          if (!root_busy) begin
            state_q <= S_MOVE;
          end
        end
        S_MOVE: begin
          axis_q[sel_q]  <= move_res;
          wrote_q[sel_q] <= move_wrote;
          if (sel_q) begin
            state_q <= S_DONE;
          end else begin
            sel_q   <= 1'b1;
            state_q <= S_GOAL;
          end
        end
        S_DONE: begin
          if (load) begin
            pos_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pos_o.valid       = pos_valid_q;
  assign pos_o.x_position  = x_pos_q;
  assign pos_o.y_position  = y_pos_q;
  assign pos_o.x_written   = x_wr_q;
  assign pos_o.y_written   = y_wr_q;
  assign pos_o.x_pulse_off = x_off_q;
  assign pos_o.y_pulse_off = y_off_q;

`ifndef NO_ASSERTIONS
  a_root_in_root_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_busy |-> state_q == S_ROOT)
    else $error("square-root unit busy outside root state");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pos_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised without finishing an item");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q[0].speed != -7'sd64 && axis_q[1].speed != -7'sd64)
    else $error("velocity left the +/-63 range");

  a_relaxed_at_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) && axis_q[0].relaxed
    |-> axis_q[0].now == '0 && axis_q[0].goal == '0)
    else $error("x pulse off while not resting at zero");
`endif

endmodule

/* design/tasp_isqrt.sv */
// ----------------------------------------------------------------------------
// tasp_isqrt
// Iterative floor square root, one result bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tasp_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tasp_pkg::RAD_W-1:0]  rad_i,
  output logic                        busy_o,
  output logic [tasp_pkg::ROOT_W-1:0] root_o
);
  import tasp_pkg::*;

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W-1:0] bit_q;
  logic [ROOT_W-1:0] cand;
  logic [RAD_W-1:0]  sq;

  assign cand   = root_q | bit_q;
  assign sq     = RAD_W'(cand) * RAD_W'(cand);
  assign busy_o = |bit_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= {1'b1, {(ROOT_W-1){1'b0}}};
    end else begin
      bit_q <= bit_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
    end else if (busy_o && (sq <= rad_q)) begin
      root_q <= cand;
    end
  end

endmodule

/* design/tasp_axis_alu.sv */
// ----------------------------------------------------------------------------
// tasp_axis_alu
// Per-axis arithmetic, shared by both axes: goal update with deadband and
// reversal handling, then velocity slew, snap and stable-sample counting.
// ----------------------------------------------------------------------------
module tasp_axis_alu (
  input  tasp_pkg::axis_state_t              st_i,
  input  logic signed [tasp_pkg::POS_W-1:0]  req_i,
  input  tasp_pkg::cfg_t                     cfg_i,
  input  logic [tasp_pkg::ROOT_W-1:0]        root_i,
  output tasp_pkg::goal_res_t                goal_o,
  output tasp_pkg::axis_state_t              move_o,
  output logic                               wrote_o
);
  import tasp_pkg::*;

  // goal stage
  logic signed [11:0]      diff;
  logic [11:0]             abs_diff;
  logic signed [POS_W-1:0] g_new;
  logic                    flip;
  logic [3:0]              g_acc;
  logic signed [DLT_W-1:0] g_delta;
  logic [DLT_W-1:0]        g_abs;

  always_comb begin
    diff     = {req_i[POS_W-1], req_i} - {st_i.goal[POS_W-1], st_i.goal};
    abs_diff = diff[11] ? 12'(-diff) : 12'(diff);
    g_new    = (abs_diff >= {6'b0, cfg_i.deadband}) ? req_i : st_i.goal;
    flip     = (st_i.goal != '0) && (g_new != '0) &&
               (st_i.goal[POS_W-1] != g_new[POS_W-1]);
    g_acc    = (g_new == '0) ? cfg_i.ctr_accel : cfg_i.accel;
    g_delta  = {{(DLT_W-POS_W){g_new[POS_W-1]}}, g_new} -
               {{(DLT_W-NOW_W){st_i.now[NOW_W-1]}}, st_i.now};
    g_abs    = g_delta[DLT_W-1] ? DLT_W'(-g_delta) : DLT_W'(g_delta);
    goal_o.goal     = g_new;
    goal_o.speed    = flip ? '0 : st_i.speed;
    goal_o.radicand = RAD_W'({g_acc, 1'b0}) * RAD_W'(g_abs[NOW_W-1:0]);
  end

  // move stage, on a state whose goal is already updated
  logic                    m_center;
  logic [5:0]              m_vmax;
  logic [3:0]              m_acc;
  logic signed [DLT_W-1:0] m_delta;
  logic [DLT_W-1:0]        m_abs;
  logic [5:0]              m_want;
  logic signed [7:0]       tgt;
  logic signed [7:0]       sp8;
  logic signed [7:0]       d8;
  logic signed [7:0]       acc8;
  logic signed [7:0]       v8;
  logic [7:0]              abs_v;
  logic signed [NOW_W-1:0] nxt;
  logic signed [SPD_W-1:0] spd;
  logic [3:0]              cnt_inc;

  always_comb begin
    m_center = (st_i.goal == '0);
    m_vmax   = m_center ? cfg_i.ctr_vel : cfg_i.max_vel;
    m_acc    = m_center ? cfg_i.ctr_accel : cfg_i.accel;
    m_delta  = {{(DLT_W-POS_W){st_i.goal[POS_W-1]}}, st_i.goal} -
               {{(DLT_W-NOW_W){st_i.now[NOW_W-1]}}, st_i.now};
    m_abs    = m_delta[DLT_W-1] ? DLT_W'(-m_delta) : DLT_W'(m_delta);
    m_want   = (root_i > {3'b000, m_vmax}) ? m_vmax : root_i[5:0];
    if (m_delta < 0) begin
      tgt = -$signed({2'b00, m_want});
    end else if (m_delta == '0) begin
      tgt = '0;
    end else begin
      tgt = $signed({2'b00, m_want});
    end
    sp8  = {st_i.speed[SPD_W-1], st_i.speed};
    acc8 = $signed({4'b0000, m_acc});
    d8   = tgt - sp8;
    if (d8 > acc8) begin
      v8 = sp8 + acc8;
    end else if (d8 < -acc8) begin
      v8 = sp8 - acc8;
    end else begin
      v8 = tgt;
    end
    abs_v = v8[7] ? 8'(-v8) : 8'(v8);

    if (m_delta == '0) begin
      spd = '0;
      nxt = st_i.now;
    end else if (m_abs <= {6'b0, abs_v}) begin
      spd = '0;
      nxt = {{(NOW_W-POS_W){st_i.goal[POS_W-1]}}, st_i.goal};
    end else begin
      spd = v8[SPD_W-1:0];
      nxt = st_i.now + {{(NOW_W-8){v8[7]}}, v8};
    end

    wrote_o      = (nxt != st_i.now);
    cnt_inc      = st_i.cnt + 4'd1;
    move_o       = st_i;
    move_o.now   = nxt;
    move_o.speed = spd;
    if (wrote_o || (nxt != '0) || (st_i.goal != '0)) begin
      move_o.cnt     = '0;
      move_o.relaxed = 1'b0;
    end else if (!st_i.relaxed) begin
      move_o.cnt     = cnt_inc;
      move_o.relaxed = (cnt_inc >= cfg_i.relax);
    end
  end

endmodule
